/* hdl/swbl_pkg.sv */
// ============================================================================
// swbl_pkg: shared definitions for the sliding window bandwidth limiter
// Slot ring geometry, field widths, the rate constant and the structs that
// pass between the top level and the rate check unit.
// ============================================================================
`default_nettype none

package swbl_pkg;

  localparam int unsigned SLOT_COUNT = 1024;
  localparam int unsigned PTR_W      = $clog2(SLOT_COUNT);
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned BYTE_W     = 32;
  localparam int unsigned LIMIT_W    = 32;
  localparam int unsigned MUL_W      = 32;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned WIDE_W     = TIME_W + LIMIT_W;

  // Picoseconds per second divided by 1024 bytes per kilobyte.
  localparam logic [MUL_W-1:0] PS_PER_SEC_OVER_KB = 32'd976562500;

  typedef logic [PTR_W-1:0] ptr_t;

  localparam ptr_t PTR_LAST = ptr_t'(SLOT_COUNT - 1);

  typedef struct packed {
    logic [TIME_W-1:0] slot_time;
    logic [BYTE_W-1:0] slot_bytes;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic               start;
    logic [BYTE_W-1:0]  byte_sum;
    logic [TIME_W-1:0]  span;
    logic [LIMIT_W-1:0] limit;
  } check_req_t;

  typedef struct packed {
    logic done;
    logic below;
  } check_rsp_t;

endpackage

`default_nettype wire

/* hdl/swbl_cfg_if.sv */
// ============================================================================
// swbl_cfg_if: limit register write channel
// Carries one write of the bandwidth limit per beat.
// ============================================================================
`default_nettype none

interface swbl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [swbl_pkg::LIMIT_W-1:0]  limit_kb_per_sec;

  modport source (output valid, output limit_kb_per_sec, input ready);
  modport sink (input valid, input limit_kb_per_sec, output ready);
endinterface

`default_nettype wire

/* hdl/swbl_txn_if.sv */
// ============================================================================
// swbl_txn_if: transaction input channel
// Carries one timestamped transaction per beat.
// ============================================================================
`default_nettype none

interface swbl_txn_if;
  logic                         valid;
  logic                         ready;
  logic [swbl_pkg::TIME_W-1:0]  now_ps;
  logic [swbl_pkg::BYTE_W-1:0]  byte_count;

  modport source (output valid, output now_ps, output byte_count, input ready);
  modport sink (input valid, input now_ps, input byte_count, output ready);
endinterface

`default_nettype wire

/* hdl/swbl_res_if.sv */
// ============================================================================
// swbl_res_if: limiter result channel
// Carries the limit decision and the window byte sum, one beat per transaction.
// ============================================================================
`default_nettype none

interface swbl_res_if;
  logic                         valid;
  logic                         ready;
  logic                         within_limit;
  logic [swbl_pkg::BYTE_W-1:0]  window_bytes;

  modport source (output valid, output within_limit, output window_bytes, input ready);
  modport sink (input valid, input within_limit, input window_bytes, output ready);
endinterface

`default_nettype wire

/* hdl/sliding_window_bandwidth_limiter.sv */
// ============================================================================
// sliding_window_bandwidth_limiter: sliding window bandwidth limiter
// Tracks bytes over a ring of recent distinct timestamps and reports whether
// the window bandwidth is below the configured kilobyte-per-second limit.
// ============================================================================
// The block takes one transaction beat at a time and returns one result beat
// for it. While the limit is zero it passes straight from idle to its output
// state; else it updates the ring, and when the window span is not zero it
// waits in its check state for the rate check, which makes three passes
// through its shared 32x32 multiplier and the final 96-bit compare. The next
// transaction is taken in the cycle after the result beat leaves, and none is
// taken before then. Slot history lives in a 1024-entry RAM that needs no
// clearing pass: a write of the limit resets the ring at once, and the limit
// is taken only while no transaction is in flight or offered.
`default_nettype none

module sliding_window_bandwidth_limiter (
  input  logic              clk,
  input  logic              rst,
  swbl_cfg_if.sink          cfg,
  swbl_txn_if.sink          txn,
  swbl_res_if.source        res
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_UPDATE = 4'b0010,
    ST_CHECK  = 4'b0100,
    ST_OUT    = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [swbl_pkg::LIMIT_W-1:0] limit;
  swbl_pkg::ptr_t               ptr;
  swbl_pkg::ptr_t               ptr_adv;
  logic                         wrapped;
  logic                         slot0_written;
  logic [swbl_pkg::TIME_W-1:0]  cur_time;
  logic [swbl_pkg::BYTE_W-1:0]  cur_bytes;
  logic [swbl_pkg::TIME_W-1:0]  span;
  logic [swbl_pkg::TIME_W-1:0]  span_next;
  logic [swbl_pkg::BYTE_W-1:0]  byte_sum;
  logic [swbl_pkg::BYTE_W-1:0]  byte_sum_next;
  logic                         flag;
  logic [swbl_pkg::TIME_W-1:0]  now_q;
  logic [swbl_pkg::BYTE_W-1:0]  bytes_q;

  logic                         txn_fire;
  logic                         cfg_fire;
  logic                         hit;
  logic                         old_valid;
  swbl_pkg::slot_t              rd_slot;
  swbl_pkg::slot_t              old_slot;
  swbl_pkg::slot_t              wr_slot;
  swbl_pkg::ptr_t               wr_addr;
  logic                         wr_en;
  swbl_pkg::check_req_t         check_req;
  swbl_pkg::check_rsp_t         check_rsp;

  assign txn.ready = (state == ST_IDLE);
  assign cfg.ready = (state == ST_IDLE) && !txn.valid;
  assign txn_fire  = txn.valid && txn.ready;
  assign cfg_fire  = cfg.valid && cfg.ready;

  assign ptr_adv = (ptr == swbl_pkg::PTR_LAST) ? '0 : ptr + 1'b1;

  // An entry not written since the last clear reads as an empty slot.
  assign old_valid = (ptr_adv == '0) ? slot0_written : wrapped;
  assign old_slot  = old_valid ? rd_slot : '0;
  assign hit       = (cur_time == now_q);

  assign span_next     = hit ? span : now_q - old_slot.slot_time;
  assign byte_sum_next = hit ? byte_sum + bytes_q
                             : byte_sum + bytes_q - old_slot.slot_bytes;

  assign wr_en                = (state == ST_UPDATE);
  assign wr_addr              = hit ? ptr : ptr_adv;
  assign wr_slot.slot_time    = now_q;
  assign wr_slot.slot_bytes   = hit ? cur_bytes + bytes_q : bytes_q;

  swbl_ram #(
    .WIDTH (swbl_pkg::SLOT_W),
    .DEPTH (swbl_pkg::SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_slot),
    .raddr (ptr_adv),
    .rdata (rd_slot)
  );

  assign check_req.start    = (state == ST_UPDATE) && (span_next != '0);
  assign check_req.byte_sum = byte_sum;
  assign check_req.span     = span;
  assign check_req.limit    = limit;

  swbl_rate_check u_rate_check (
    .clk (clk),
    .rst (rst),
    .req (check_req),
    .rsp (check_rsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (txn_fire) begin
          state_next = (limit == '0) ? ST_OUT : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = (span_next != '0) ? ST_CHECK : ST_OUT;
      end
      ST_CHECK: begin
        if (check_rsp.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (res.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      limit         <= '0;
      ptr           <= '0;
      wrapped       <= 1'b0;
      slot0_written <= 1'b0;
      cur_time      <= '0;
      cur_bytes     <= '0;
      span          <= '0;
      byte_sum      <= '0;
      flag          <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_fire) begin
        limit         <= cfg.limit_kb_per_sec;
        ptr           <= '0;
        wrapped       <= 1'b0;
        slot0_written <= 1'b0;
        cur_time      <= '0;
        cur_bytes     <= '0;
        span          <= '0;
        byte_sum      <= '0;
        flag          <= 1'b1;
      end
      if (state == ST_UPDATE) begin
        span      <= span_next;
        byte_sum  <= byte_sum_next;
        cur_time  <= wr_slot.slot_time;
        cur_bytes <= wr_slot.slot_bytes;
        ptr       <= wr_addr;
        if (wr_addr == '0) begin
          slot0_written <= 1'b1;
        end
        if (!hit && (ptr_adv == '0)) begin
          wrapped <= 1'b1;
        end
      end
      if ((state == ST_CHECK) && check_rsp.done) begin
        flag <= check_rsp.below;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (txn_fire) begin
      now_q   <= txn.now_ps;
      bytes_q <= txn.byte_count;
    end
  end

  assign res.valid        = (state == ST_OUT);
  assign res.within_limit = flag;
  assign res.window_bytes = byte_sum;

endmodule

`default_nettype wire

/* hdl/swbl_ram.sv */
// ============================================================================
// swbl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
`default_nettype none

module swbl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/swbl_rate_check.sv */
// ============================================================================
// swbl_rate_check: iterative window rate compare
// Decides byte_sum * 976562500 / span < limit as byte_sum * 976562500 <
// limit * span, using one shared 32x32 multiplier over three passes.
// ============================================================================
`default_nettype none

module swbl_rate_check (
  input  logic                 clk,
  input  logic                 rst,
  input  swbl_pkg::check_req_t req,
  output swbl_pkg::check_rsp_t rsp
);

  typedef enum logic [4:0] {
    CK_IDLE  = 5'b00001,
    CK_MUL_A = 5'b00010,
    CK_MUL_B = 5'b00100,
    CK_MUL_C = 5'b01000,
    CK_CMP   = 5'b10000
  } ck_state_t;

  ck_state_t state;
  ck_state_t state_next;

  logic [swbl_pkg::MUL_W-1:0]  mul_a;
  logic [swbl_pkg::MUL_W-1:0]  mul_b;
  logic [swbl_pkg::PROD_W-1:0] mul_q;
  logic [swbl_pkg::PROD_W-1:0] rate_prod;
  logic [swbl_pkg::PROD_W-1:0] limit_lo;
  logic [swbl_pkg::WIDE_W-1:0] limit_span;

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      CK_IDLE: begin
        if (req.start) begin
          state_next = CK_MUL_A;
        end
      end
      CK_MUL_A: begin
        mul_a      = req.byte_sum;
        mul_b      = swbl_pkg::PS_PER_SEC_OVER_KB;
        state_next = CK_MUL_B;
      end
      CK_MUL_B: begin
        mul_a      = req.limit;
        mul_b      = req.span[swbl_pkg::MUL_W-1:0];
        state_next = CK_MUL_C;
      end
      CK_MUL_C: begin
        mul_a      = req.limit;
        mul_b      = req.span[swbl_pkg::TIME_W-1:swbl_pkg::MUL_W];
        state_next = CK_CMP;
      end
      CK_CMP: begin
        state_next = CK_IDLE;
      end
      default: begin
        state_next = CK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
    if (state == CK_MUL_B) begin
      rate_prod <= mul_q;
    end
    if (state == CK_MUL_C) begin
      limit_lo <= mul_q;
    end
  end

  assign limit_span = {mul_q, {swbl_pkg::MUL_W{1'b0}}}
                    + {{(swbl_pkg::WIDE_W - swbl_pkg::PROD_W){1'b0}}, limit_lo};

  assign rsp.done  = (state == CK_CMP);
  assign rsp.below = {{(swbl_pkg::WIDE_W - swbl_pkg::PROD_W){1'b0}}, rate_prod} < limit_span;

endmodule

`default_nettype wire

/* hdl/swbl_checker.sv */
// ============================================================================
// swbl_checker: port-level checks for the bandwidth limiter
// Watches the channels of the top level and flags ordering slips.
// ============================================================================
`default_nettype none

module swbl_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic                         txn_valid,
  input logic                         txn_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic                         res_within_limit,
  input logic [swbl_pkg::BYTE_W-1:0]  res_window_bytes
);

  logic txn_fire;
  logic cfg_fire;
  logic res_fire;

  assign txn_fire = txn_valid && txn_ready;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign res_fire = res_valid && res_ready;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_within_limit)
                                && $stable(res_window_bytes))
    else $error("Result beat changed while stalled.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !txn_ready)
    else $error("Transaction taken while a result is pending.");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    txn_fire |=> !txn_ready)
    else $error("Block ready again right after taking a transaction.");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    res_fire |=> !res_valid)
    else $error("More than one result beat for one transaction.");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_fire |=> txn_ready && !res_valid)
    else $error("Limit write did not leave the block idle.");

endmodule

bind sliding_window_bandwidth_limiter swbl_checker u_swbl_checker (
  .clk              (clk),
  .rst              (rst),
  .cfg_valid        (cfg.valid),
  .cfg_ready        (cfg.ready),
  .txn_valid        (txn.valid),
  .txn_ready        (txn.ready),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_within_limit (res.within_limit),
  .res_window_bytes (res.window_bytes)
);

`default_nettype wire

/* test/tb_sliding_window_bandwidth_limiter.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_sliding_window_bandwidth_limiter: self-checking bench for the limiter
// Drives timestamped transactions and limit writes through the three
// channels. It keeps its own copy of the slot ring and window state to
// predict each result beat, and compares every field in order of arrival.
// Both sides idle at random; the run includes a long result stall, a long
// run of advancing timestamps and a final stretch at full rate.
// ============================================================================

module tb_sliding_window_bandwidth_limiter;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;

  typedef struct {
    logic                        in_limit;
    logic [swbl_pkg::BYTE_W-1:0] bytes;
  } window_verdict_t;

  logic clk;
  logic rst;

  swbl_cfg_if cfg_bus ();
  swbl_txn_if txn_bus ();
  swbl_res_if res_bus ();

  sliding_window_bandwidth_limiter u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .txn (txn_bus),
    .res (res_bus)
  );

  logic [swbl_pkg::TIME_W-1:0]  ring_time [swbl_pkg::SLOT_COUNT];
  logic [swbl_pkg::BYTE_W-1:0]  ring_bytes [swbl_pkg::SLOT_COUNT];
  swbl_pkg::ptr_t               ring_ptr;
  logic [swbl_pkg::TIME_W-1:0]  span_ps;
  logic [swbl_pkg::BYTE_W-1:0]  sum_bytes;
  logic                         under_flag;
  logic [swbl_pkg::LIMIT_W-1:0] limit_kbps;

  window_verdict_t verdict_q[$];
  window_verdict_t want;
  logic [swbl_pkg::TIME_W-1:0] cur_ps;

  int errors;
  int txn_sent;
  int results_checked;
  int limit_writes;
  int quiet_cycles;
  int hold_req;
  int stall_left;
  bit src_idle_en;
  bit sink_idle_en;

  function automatic void clear_window();
    for (int i = 0; i < swbl_pkg::SLOT_COUNT; i++) begin
      ring_time[i]  = '0;
      ring_bytes[i] = '0;
    end
    ring_ptr   = '0;
    span_ps    = '0;
    sum_bytes  = '0;
    under_flag = 1'b1;
  endfunction

  function automatic window_verdict_t predict_window(
      input logic [swbl_pkg::TIME_W-1:0] stamp,
      input logic [swbl_pkg::BYTE_W-1:0] nbytes);
    window_verdict_t v;
    logic [63:0] product;
    logic [63:0] rate;
    if (limit_kbps != '0) begin
      if (ring_time[ring_ptr] == stamp) begin
        ring_bytes[ring_ptr] += nbytes;
        sum_bytes            += nbytes;
      end else begin
        ring_ptr             = (ring_ptr == swbl_pkg::PTR_LAST) ? swbl_pkg::ptr_t'(0)
                                                               : ring_ptr + 1'b1;
        span_ps              = stamp - ring_time[ring_ptr];
        sum_bytes            = sum_bytes + nbytes - ring_bytes[ring_ptr];
        ring_bytes[ring_ptr] = nbytes;
        ring_time[ring_ptr]  = stamp;
      end
      if (span_ps != '0) begin
        product    = {32'b0, sum_bytes} * {32'b0, swbl_pkg::PS_PER_SEC_OVER_KB};
        rate       = product / span_ps;
        under_flag = rate < {32'b0, limit_kbps};
      end
    end
    v.in_limit = under_flag;
    v.bytes    = sum_bytes;
    return v;
  endfunction

  function automatic logic [swbl_pkg::TIME_W-1:0] pick_stamp();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      cur_ps += $urandom_range(1, 4000);
    end else if (roll < 82) begin
      return cur_ps;
    end else if (roll < 90) begin
      cur_ps -= $urandom_range(1, 4000);
    end else begin
      cur_ps = {$urandom, $urandom};
    end
    return cur_ps;
  endfunction

  function automatic logic [swbl_pkg::BYTE_W-1:0] pick_bytes();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      return $urandom_range(0, 255);
    end else if (roll < 90) begin
      return $urandom;
    end else if (roll < 95) begin
      return '0;
    end
    return '1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    res_bus.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (verdict_q.size() == 0) begin
        $error("result beat with no transaction pending: within_limit %0b window_bytes %0d",
               res_bus.within_limit, res_bus.window_bytes);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        results_checked++;
        if (res_bus.within_limit !== want.in_limit) begin
          $error("within_limit: expected %0b, got %0b", want.in_limit, res_bus.within_limit);
          errors++;
        end
        if (res_bus.window_bytes !== want.bytes) begin
          $error("window_bytes: expected %0d, got %0d", want.bytes, res_bus.window_bytes);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (txn_bus.valid && txn_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("sliding_window_bandwidth_limiter: mismatch");
      $finish;
    end
  end

  task automatic send_txn(input logic [swbl_pkg::TIME_W-1:0] stamp,
                          input logic [swbl_pkg::BYTE_W-1:0] nbytes);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      txn_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    txn_bus.valid      <= 1'b1;
    txn_bus.now_ps     <= stamp;
    txn_bus.byte_count <= nbytes;
    do @(posedge clk); while (!txn_bus.ready);
    verdict_q.push_back(predict_window(stamp, nbytes));
    txn_sent++;
  endtask

  task automatic drain_results();
    txn_bus.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_limit(input logic [swbl_pkg::LIMIT_W-1:0] value);
    drain_results();
    cfg_bus.valid            <= 1'b1;
    cfg_bus.limit_kb_per_sec <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    limit_kbps = value;
    clear_window();
    cur_ps = '0;
    limit_writes++;
  endtask

  task automatic test_disabled_after_reset();
    send_txn('0, '0);
    send_txn('1, '1);
    send_txn(64'd12345, 32'd77);
  endtask

  task automatic test_directed_edges();
    write_limit(32'd1);
    send_txn(64'd0, 32'd100);
    send_txn(64'd5, 32'd50);
    send_txn(64'd0, 32'd10);
    send_txn(64'd5, 32'd0);
    send_txn('1, '1);
    send_txn(64'd3, '1);
    send_txn(64'd3, 32'd1);
    write_limit('1);
    send_txn(64'd1, 32'd0);
    send_txn(64'd2, '1);
    send_txn(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
    send_txn(64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
    send_txn(64'd100_000_000_000, 32'd1);
    write_limit(32'd0);
    send_txn('1, '1);
    send_txn(64'd0, 32'd0);
  endtask

  task automatic test_ring_advance();
    write_limit(32'd60_000_000);
    for (int i = 0; i < 150; i++) begin
      if ($urandom_range(0, 9) != 0) cur_ps += $urandom_range(1, 4000);
      send_txn(cur_ps, $urandom_range(0, 255));
    end
  endtask

  task automatic test_backpressure();
    write_limit(32'd50_000_000);
    hold_req = LONG_HOLD;
    for (int i = 0; i < 24; i++) send_txn(pick_stamp(), pick_bytes());
    drain_results();
    for (int i = 0; i < 8; i++) send_txn(pick_stamp(), pick_bytes());
  endtask

  task automatic test_random_limits();
    logic [swbl_pkg::LIMIT_W-1:0] lim;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: lim = $urandom;
        1: lim = '0;
        2: lim = 32'd1;
        3: lim = '1;
        default: lim = $urandom_range(10_000_000, 200_000_000);
      endcase
      write_limit(lim);
      for (int i = 0; i < 25; i++) send_txn(pick_stamp(), pick_bytes());
    end
  endtask

  task automatic test_full_rate();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    write_limit($urandom_range(10_000_000, 200_000_000));
    for (int i = 0; i < 60; i++) send_txn(pick_stamp(), pick_bytes());
  endtask

  initial begin
    errors          = 0;
    txn_sent        = 0;
    results_checked = 0;
    limit_writes    = 0;
    hold_req        = 0;
    src_idle_en     = 1'b1;
    sink_idle_en    = 1'b1;
    cur_ps          = '0;
    limit_kbps      = '0;
    clear_window();
    rst                      <= 1'b1;
    txn_bus.valid            <= 1'b0;
    txn_bus.now_ps           <= '0;
    txn_bus.byte_count       <= '0;
    cfg_bus.valid            <= 1'b0;
    cfg_bus.limit_kb_per_sec <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_disabled_after_reset();
    test_directed_edges();
    test_ring_advance();
    test_backpressure();
    test_random_limits();
    test_full_rate();
    drain_results();

    $display("Sent %0d transactions over %0d limit settings and checked %0d results,",
             txn_sent, limit_writes, results_checked);
    $display("covering the disabled limiter, zero span, byte wrap, time going back and stalls.");
    if (errors == 0) begin
      $display("sliding_window_bandwidth_limiter: match");
    end else begin
      $display("sliding_window_bandwidth_limiter: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/swbl_pkg.sv
hdl/swbl_cfg_if.sv
hdl/swbl_txn_if.sv
hdl/swbl_res_if.sv
hdl/swbl_ram.sv
hdl/swbl_rate_check.sv
hdl/sliding_window_bandwidth_limiter.sv
hdl/swbl_checker.sv
test/tb_sliding_window_bandwidth_limiter.sv
